FILE: hw/rtl/merge_insertion_sorter_macros.svh
// Assertion helpers for the sorter. Both sample on clk and are off during rst.
`ifndef MERGE_INSERTION_SORTER_MACROS_SVH
`define MERGE_INSERTION_SORTER_MACROS_SVH

// Same-cycle implication.
`define MIS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mis_pkg.sv
`default_nettype none
package mis_pkg;

  localparam int VALUE_W = 31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch input value, final mark, start scan at the top
    logic set_drop;    // store full: mark the list as overflowed
    logic scan_rd;     // read entry k-1
    logic shift_wr;    // move entry k-1 up to k, step k down
    logic place_wr;    // write the new value at k, count up
    logic emit_start;  // reset the emit index
    logic emit_rd;     // read entry at the emit index
    logic emit_load;   // load the output register, step the emit index
    logic clear_list;  // start a new list
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic k_zero;
    logic rdata_ge;
    logic last;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mis_ram.sv
`default_nettype none
module mis_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mis_datapath.sv
`default_nettype none
module mis_datapath import mis_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 st,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               final_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [VALUE_W-1:0] sorted_value,
  output logic                    final_result,
  output logic                    overflow
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [VALUE_W-1:0] v;
  logic               last;
  logic [CW-1:0]      k;
  logic [CW-1:0]      count;
  logic               dropped;
  logic [CW-1:0]      idx;

  logic [CW-1:0]      k_m1;
  logic [CW-1:0]      count_m1;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  assign k_m1     = k - CW'(1);
  assign count_m1 = count - CW'(1);

  assign ram_we    = cmd.shift_wr | cmd.place_wr;
  assign ram_waddr = k[AW-1:0];
  assign ram_wdata = cmd.shift_wr ? ram_rdata : v;
  assign ram_re    = cmd.scan_rd | cmd.emit_rd;
  assign ram_raddr = cmd.emit_rd ? idx[AW-1:0] : k_m1[AW-1:0];

  mis_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign st.full      = (count == CW'(MAX_ITEMS));
  assign st.k_zero    = (k == '0);
  assign st.rdata_ge  = (ram_rdata >= v);
  assign st.last      = last;
  assign st.emit_last = (idx == count_m1);
  assign st.out_free  = ~out_valid | ~out_stall;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v    <= value;
      last <= final_item;
    end
    if (cmd.emit_load) begin
      sorted_value <= ram_rdata;
      final_result <= st.emit_last;
      overflow     <= dropped;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      count     <= '0;
      dropped   <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        k <= count;
      end else if (cmd.shift_wr) begin
        k <= k_m1;
      end
      if (cmd.clear_list) begin
        count <= '0;
      end else if (cmd.place_wr) begin
        count <= count + CW'(1);
      end
      if (cmd.clear_list) begin
        dropped <= 1'b0;
      end else if (cmd.set_drop) begin
        dropped <= 1'b1;
      end
      if (cmd.emit_start) begin
        idx <= '0;
      end else if (cmd.emit_load) begin
        idx <= idx + CW'(1);
      end
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mis_ctrl.sv
`default_nettype none
module mis_ctrl import mis_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_EREAD,
    S_ELOAD
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (st.full) begin
          cmd.set_drop = 1'b1;
          if (st.last) begin
            cmd.emit_start = 1'b1;
            state_next     = S_EREAD;
          end else begin
            state_next = S_IDLE;
          end
        end else if (st.k_zero) begin
          cmd.place_wr = 1'b1;
          if (st.last) begin
            cmd.emit_start = 1'b1;
            state_next     = S_EREAD;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (st.rdata_ge) begin
          cmd.shift_wr = 1'b1;
          state_next   = S_SCAN;
        end else begin
          cmd.place_wr = 1'b1;
          if (st.last) begin
            cmd.emit_start = 1'b1;
            state_next     = S_EREAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EREAD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_ELOAD;
      end
      S_ELOAD: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          if (st.emit_last) begin
            cmd.clear_list = 1'b1;
            state_next     = S_IDLE;
          end else begin
            state_next = S_EREAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/merge_insertion_sorter.sv
// merge_insertion_sorter: collects a list of 31-bit unsigned values and returns
// them in ascending order (duplicates kept) after the value marked final_item.
// Input channel: in_valid/in_stall with value and final_item; a transfer takes
// place when in_valid is high and in_stall low. Output channel: out_valid/
// out_stall with sorted_value, final_result (last of the list) and overflow
// (set on every result of a list that lost values past MAX_ITEMS).
// Each value is inserted into a sorted single-port-read store: the scan walks
// down from the top, entry by entry (RAM read, then compare and move), and
// moves up every held value not smaller than the new one. After the final
// value, the results leave one at a time, each by a RAM read and then a load
// into the output register. A stall on the output holds the output register
// and pauses the drain; the input stays stalled until the last result of the
// list sits in the output register. Reset empties the list at once; the
// store itself needs no clearing pass.
`default_nettype none
module merge_insertion_sorter import mis_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               final_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [VALUE_W-1:0] sorted_value,
  output logic                    final_result,
  output logic                    overflow
);

`include "merge_insertion_sorter_macros.svh"

  cmd_t    cmd;
  status_t st;

  // Sequencer: insertion scan, then drain.
  mis_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  // Store, counters and output register.
  mis_datapath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .value       (value),
    .final_item  (final_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_value(sorted_value),
    .final_result(final_result),
    .overflow    (overflow)
  );

  // Store writes happen only while the input is held off.
  `MIS_ASSERT_IMPL(a_write_busy, cmd.shift_wr || cmd.place_wr, in_stall, "store write while idle")
  // Never insert into a full store.
  `MIS_ASSERT_IMPL(a_place_not_full, cmd.place_wr, !st.full, "insert into full store")
  // A result is loaded only into a free output slot.
  `MIS_ASSERT_IMPL(a_load_free, cmd.emit_load, st.out_free, "output register overwritten")
  // After the last result is loaded the block takes input again.
  `MIS_ASSERT_NEXT(a_drain_done, cmd.emit_load && cmd.clear_list, !in_stall, "no return to idle")

endmodule
`default_nettype wire

FILE: verif/merge_insertion_sorter_checker.sv
`default_nettype none
module merge_insertion_sorter_checker import mis_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               final_item,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [VALUE_W-1:0] sorted_value,
  input  wire logic               final_result,
  input  wire logic               overflow,
  output int                      errors,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic               last;
    logic               ovf;
  } sorted_rec_t;

  logic [VALUE_W-1:0] held_list[$];  // current list, kept ascending
  logic               list_dropped;
  sorted_rec_t        sorted_q[$];   // results still owed by the block

  initial begin
    errors       = 0;
    outstanding  = 0;
    list_dropped = 1'b0;
  end

  task automatic report(input string what, input logic [VALUE_W-1:0] got,
                        input logic [VALUE_W-1:0] want);
    errors++;
    // keep the log bounded if the block is badly broken
    if (errors <= 50)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // new value goes before the first held value that is not smaller
  function automatic void hold_value(input logic [VALUE_W-1:0] v);
    int pos = 0;
    while (pos < held_list.size() && held_list[pos] < v) pos++;
    held_list.insert(pos, v);
  endfunction

  always @(posedge clk) begin : watch
    sorted_rec_t want;
    sorted_rec_t rec;
    if (rst) begin
      held_list.delete();
      sorted_q.delete();
      list_dropped = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (held_list.size() < MAX_ITEMS) hold_value(value);
        else list_dropped = 1'b1;
        if (final_item) begin
          foreach (held_list[k]) begin
            rec = '{val:  held_list[k],
                    last: (k == held_list.size() - 1),
                    ovf:  list_dropped};
            sorted_q.insert(sorted_q.size(), rec);
          end
          held_list.delete();
          list_dropped = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        if (sorted_q.size() == 0) begin
          report("unexpected transfer, sorted_value", sorted_value, '0);
        end else begin
          want = sorted_q.pop_front();
          if (sorted_value !== want.val) report("sorted_value", sorted_value, want.val);
          if (final_result !== want.last)
            report("final_result", VALUE_W'(final_result), VALUE_W'(want.last));
          if (overflow !== want.ovf)
            report("overflow", VALUE_W'(overflow), VALUE_W'(want.ovf));
        end
      end
    end
    outstanding = sorted_q.size();
  end

endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mis_pkg::*;

  localparam int MAX_ITEMS = 64;
  // receiver hold-off for the pressure phase, in cycles
  localparam int LONG_HOLD = 400;
  // settle time after the last result: one full worst-case insertion scan
  localparam int DRAIN_CYCLES = 2 * MAX_ITEMS + 20;
  localparam logic [VALUE_W-1:0] TOP_VALUE = '1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               final_item = 1'b0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [VALUE_W-1:0] sorted_value;
  logic               final_result;
  logic               overflow;
  int                 errors;
  int                 outstanding;

  // stimulus -> receiver controls
  bit long_hold = 1'b0;  // request one long output hold-off
  bit calm      = 1'b0;  // no idling on either side

  always #1 clk = ~clk;

  merge_insertion_sorter #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .final_item  (final_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_value(sorted_value),
    .final_result(final_result),
    .overflow    (overflow)
  );

  merge_insertion_sorter_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .final_item  (final_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_value(sorted_value),
    .final_result(final_result),
    .overflow    (overflow),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll = $urandom_range(0, 19);
    if (calm || roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Extremes and small values mixed in so that duplicates show up often.
  function automatic logic [VALUE_W-1:0] pick_value();
    int roll = $urandom_range(0, 9);
    if (roll < 1) return $urandom_range(0, 1) ? TOP_VALUE : '0;
    if (roll < 4) return VALUE_W'($urandom_range(0, 7));
    return VALUE_W'($urandom);
  endfunction

  // Entered and left at a falling edge. While idle the payload carries junk,
  // which the block has to ignore; once offered it stays put until transfer.
  task automatic send_item(input logic [VALUE_W-1:0] v, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid   = 1'b0;
      value      = VALUE_W'($urandom);
      final_item = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    value      = v;
    final_item = fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // One list of len random values; the mark goes on the last one, which is
  // dropped when len is past the store size.
  task automatic send_list(input int len);
    for (int k = 0; k < len; k++) send_item(pick_value(), k == len - 1);
  endtask

  // Sender stands still until every owed result has come out.
  task automatic wait_results();
    in_valid = 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  // Receiver side: random stalls, occasional long ones, quiet stretches
  // while calm is set, and one long hold-off on request.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
        long_hold = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 40)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int roll;
    int list_len;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: single-value lists are echoed, zero and all-ones
    send_item('0, 1'b1);
    send_item(TOP_VALUE, 1'b1);
    // extremes, alternating bit patterns, duplicates at both ends
    send_item(TOP_VALUE, 1'b0);
    send_item('0, 1'b0);
    send_item(VALUE_W'(1), 1'b0);
    send_item(VALUE_W'(32'h4000_0000), 1'b0);
    send_item(VALUE_W'(32'h2AAA_AAAA), 1'b0);
    send_item(VALUE_W'(32'h5555_5555), 1'b0);
    send_item(TOP_VALUE, 1'b0);
    send_item('0, 1'b1);
    // descending order: every insertion walks the whole held list
    for (int k = 5; k >= 1; k--) send_item(VALUE_W'(k), k == 1);
    // ascending order: every insertion lands on top
    for (int k = 1; k <= 4; k++) send_item(VALUE_W'(k * 1000), k == 4);
    // all equal
    for (int k = 0; k < 3; k++) send_item(VALUE_W'(77), k == 2);
    wait_results();

    // Pressure: output held off for a long stretch while lists keep coming,
    // so the first list parks in the block and the input stalls behind it.
    calm      = 1'b1;
    long_hold = 1'b1;
    send_list(3);
    send_list(4);
    send_list(2);
    wait_results();
    calm = 1'b0;

    // Store filled exactly, then one more value carrying the final mark is dropped
    send_list(MAX_ITEMS + 1);
    wait_results();

    // Random lists, mostly short, now and then long enough to overflow
    sent = 0;
    while (sent < 64) begin
      calm = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 19);
      if (roll < 14) list_len = $urandom_range(1, 8);
      else if (roll < 19) list_len = $urandom_range(9, 30);
      else list_len = $urandom_range(40, MAX_ITEMS + 4);
      send_list(list_len);
      sent += list_len;
      if ($urandom_range(0, 7) == 0) wait_results();
    end
    calm = 1'b0;

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #1_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire
